@@ rtl/sdf_extrapolate_smooth_grid_defines.svh @@
// assertion helpers shared by the rtl files
`ifndef SDF_EXTRAPOLATE_SMOOTH_GRID_DEFINES_SVH
`define SDF_EXTRAPOLATE_SMOOTH_GRID_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define SDFX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SDFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sdfx_pkg.sv @@
package sdfx_pkg;

  // grid limits
  localparam int MAX_X = 32;
  localparam int MAX_Y = 32;
  localparam int MAX_Z = 32;

  localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int CW = XW + YW + ZW;
  localparam int AW = CW + 1;

  // effective size width, holds up to 511
  localparam int SW = 9;
  localparam int REGW = 6;
  localparam int PASSW = 8;
  localparam int DW = 32;
  // sum of six 32-bit values plus sign
  localparam int DIVW = 36;
  localparam int NW = 3;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SIZE_X        = 3'd0,
    REG_SIZE_Y        = 3'd1,
    REG_SIZE_Z        = 3'd2,
    REG_EXT_PASSES    = 3'd3,
    REG_SMOOTH_PASSES = 3'd4
  } reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GATHER,
    ST_DRAIN,
    ST_DECIDE,
    ST_DIVIDE,
    ST_WRITE,
    ST_PASS_END
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // zero acts as one, above the limit acts as the limit
  function automatic logic [SW-1:0] clamp_size(input logic [REGW-1:0] v,
                                               input logic [SW-1:0] maxv);
    logic [SW-1:0] ext;
    ext = {{(SW-REGW){1'b0}}, v};
    if (v == '0) begin
      return SW'(1);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

endpackage

@@ rtl/sdf_extrapolate_smooth_grid.sv @@
// 3d signed-distance grid with neighbor-average extrapolation and min smoothing
// command channel: start/busy; an item is taken when start is high and busy low.
//   load (0) writes one cell, read (2) returns one cell, run (1) runs
//   extrapolate_passes extrapolation passes, then smooth_passes smoothing passes
// result channel: out_strobe marks each result for one cycle, the receiver
//   cannot hold it off, so results are simply driven from registers
// apb port: five registers at byte addresses 0,4,..16, pready always high
// results: a load is registered from its accepting cycle; a read passes the ram
//   read register and the read state, busy meanwhile; one load a cycle while idle
// run: every pass sweeps all 32768 cells of the live half of one ram and writes
//   the other half (ping-pong); a cell costs 7 reads, a drain, a decide and a
//   write, plus a serial divider run when an average is formed; the result
//   strobe is registered from the end of the last pass
// reset: after rst_n the block is busy while it clears the valid flags of the
//   live half, one entry a cycle; registers may be written meanwhile
module sdf_extrapolate_smooth_grid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [4:0]         in_cell_x,
  input  logic [4:0]         in_cell_y,
  input  logic [4:0]         in_cell_z,
  input  logic signed [31:0] in_load_value,
  input  logic               in_load_valid,
  output logic               out_strobe,
  output logic signed [31:0] out_read_value,
  output logic               out_read_valid,
  output logic               out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int XW = sdfx_pkg::XW;
  localparam int YW = sdfx_pkg::YW;
  localparam int ZW = sdfx_pkg::ZW;
  localparam int CW = sdfx_pkg::CW;
  localparam int AW = sdfx_pkg::AW;
  localparam int SW = sdfx_pkg::SW;
  localparam int REGW = sdfx_pkg::REGW;
  localparam int PASSW = sdfx_pkg::PASSW;
  localparam int DW = sdfx_pkg::DW;
  localparam int DIVW = sdfx_pkg::DIVW;
  localparam int NW = sdfx_pkg::NW;
  localparam int DEPTH = 2 ** AW;

  sdfx_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [REGW-1:0]  size_x_r, size_y_r, size_z_r;
  logic [PASSW-1:0] ext_passes_r, smooth_passes_r;
  logic [SW-1:0]    sx, sy, sz;

  // sweep control
  logic [CW-1:0]    cell_r;
  logic [2:0]       nb_r;
  logic             mode_ext_r;
  logic [PASSW-1:0] pass_cnt_r;
  logic             bank_r;
  logic             more_passes;

  // read pipeline and per-cell accumulation
  logic             rd_pend_r;
  logic [2:0]       rd_k_r;
  logic             rd_use_r;
  logic [DW-1:0]    own_val_r;
  logic             own_vld_r;
  logic signed [DIVW-1:0] sum_r;
  logic [NW-1:0]    n_r;
  logic [DW-1:0]    res_val_r;
  logic             res_vld_r;

  // memory
  logic [DW:0]      mem [0:DEPTH-1];
  logic [DW:0]      mem_rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [DW:0]      mem_wdata;

  // output registers
  logic             out_strobe_r, out_strobe_nxt;
  logic [DW-1:0]    out_read_value_r, out_read_value_nxt;
  logic             out_read_valid_r, out_read_valid_nxt;
  logic             out_status_r, out_status_nxt;

  // divider
  sdfx_pkg::div_stat_t div_stat;
  logic             div_start;
  logic [DIVW-1:0]  div_dividend;
  logic [DIVW-1:0]  div_quotient;

  logic             accept;
  logic             in_inside;
  logic [CW-1:0]    in_cell;
  logic [XW-1:0]    cx;
  logic [YW-1:0]    cy;
  logic [ZW-1:0]    cz;
  logic             cell_inside;
  logic [CW-1:0]    nb_addr;
  logic             nb_use;
  logic             need_div;
  logic [DIVW-1:0]  avg_wide;
  logic signed [DW-1:0] avg;
  logic             cfg_wr;

  // apb register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r        <= REGW'(32);
      size_y_r        <= REGW'(32);
      size_z_r        <= REGW'(32);
      ext_passes_r    <= '0;
      smooth_passes_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        sdfx_pkg::REG_SIZE_X:        size_x_r <= pwdata[REGW-1:0];
        sdfx_pkg::REG_SIZE_Y:        size_y_r <= pwdata[REGW-1:0];
        sdfx_pkg::REG_SIZE_Z:        size_z_r <= pwdata[REGW-1:0];
        sdfx_pkg::REG_EXT_PASSES:    ext_passes_r <= pwdata[PASSW-1:0];
        sdfx_pkg::REG_SMOOTH_PASSES: smooth_passes_r <= pwdata[PASSW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      sdfx_pkg::REG_SIZE_X:        prdata = {{(32-REGW){1'b0}}, size_x_r};
      sdfx_pkg::REG_SIZE_Y:        prdata = {{(32-REGW){1'b0}}, size_y_r};
      sdfx_pkg::REG_SIZE_Z:        prdata = {{(32-REGW){1'b0}}, size_z_r};
      sdfx_pkg::REG_EXT_PASSES:    prdata = {{(32-PASSW){1'b0}}, ext_passes_r};
      sdfx_pkg::REG_SMOOTH_PASSES: prdata = {{(32-PASSW){1'b0}}, smooth_passes_r};
      default:                     prdata = '0;
    endcase
  end

  // effective sizes
  assign sx = sdfx_pkg::clamp_size(size_x_r, SW'(sdfx_pkg::MAX_X));
  assign sy = sdfx_pkg::clamp_size(size_y_r, SW'(sdfx_pkg::MAX_Y));
  assign sz = sdfx_pkg::clamp_size(size_z_r, SW'(sdfx_pkg::MAX_Z));

  // command address decode
  assign accept    = start && !busy;
  assign in_inside = (SW'(in_cell_x) < sx) && (SW'(in_cell_y) < sy) && (SW'(in_cell_z) < sz);
  assign in_cell   = {ZW'(in_cell_z), YW'(in_cell_y), XW'(in_cell_x)};

  // sweep cell coordinates
  assign cx = cell_r[XW-1:0];
  assign cy = cell_r[XW +: YW];
  assign cz = cell_r[XW+YW +: ZW];
  assign cell_inside = (SW'(cx) < sx) && (SW'(cy) < sy) && (SW'(cz) < sz);

  // center first, then the six neighbors
  always_comb begin
    nb_addr = cell_r;
    nb_use  = 1'b0;
    unique case (nb_r)
      3'd0: begin
        nb_use = 1'b1;
      end
      3'd1: begin
        nb_addr = {cz, cy, cx - XW'(1)};
        nb_use  = cx != '0;
      end
      3'd2: begin
        nb_addr = {cz, cy, cx + XW'(1)};
        nb_use  = (SW'(cx) + SW'(1)) < sx;
      end
      3'd3: begin
        nb_addr = {cz, cy - YW'(1), cx};
        nb_use  = cy != '0;
      end
      3'd4: begin
        nb_addr = {cz, cy + YW'(1), cx};
        nb_use  = (SW'(cy) + SW'(1)) < sy;
      end
      3'd5: begin
        nb_addr = {cz - ZW'(1), cy, cx};
        nb_use  = cz != '0;
      end
      3'd6: begin
        nb_addr = {cz + ZW'(1), cy, cx};
        nb_use  = (SW'(cz) + SW'(1)) < sz;
      end
      default: ;
    endcase
  end

  // averaging decisions
  assign need_div     = cell_inside && (n_r != '0) && !(mode_ext_r && own_vld_r);
  assign div_dividend = sum_r[DIVW-1] ? DIVW'(-sum_r) : DIVW'(sum_r);
  assign avg_wide     = sum_r[DIVW-1] ? (DIVW'(0) - div_quotient) : div_quotient;
  assign avg          = avg_wide[DW-1:0];
  assign more_passes  = (pass_cnt_r > PASSW'(1)) || (mode_ext_r && smooth_passes_r != '0);

  sdfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_r),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdfx_pkg::ST_CLEAR: begin
        if (&cell_r) state_nxt = sdfx_pkg::ST_IDLE;
      end
      sdfx_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_command)
            sdfx_pkg::CMD_READ: begin
              if (in_inside) state_nxt = sdfx_pkg::ST_READ;
            end
            sdfx_pkg::CMD_RUN: begin
              if (ext_passes_r != '0 || smooth_passes_r != '0) begin
                state_nxt = sdfx_pkg::ST_GATHER;
              end
            end
            default: ;
          endcase
        end
      end
      sdfx_pkg::ST_READ:   state_nxt = sdfx_pkg::ST_IDLE;
      sdfx_pkg::ST_GATHER: begin
        if (nb_r == 3'd6) state_nxt = sdfx_pkg::ST_DRAIN;
      end
      sdfx_pkg::ST_DRAIN:  state_nxt = sdfx_pkg::ST_DECIDE;
      sdfx_pkg::ST_DECIDE: begin
        state_nxt = need_div ? sdfx_pkg::ST_DIVIDE : sdfx_pkg::ST_WRITE;
      end
      sdfx_pkg::ST_DIVIDE: begin
        if (div_stat.done) state_nxt = sdfx_pkg::ST_WRITE;
      end
      sdfx_pkg::ST_WRITE: begin
        state_nxt = (&cell_r) ? sdfx_pkg::ST_PASS_END : sdfx_pkg::ST_GATHER;
      end
      sdfx_pkg::ST_PASS_END: begin
        state_nxt = more_passes ? sdfx_pkg::ST_GATHER : sdfx_pkg::ST_IDLE;
      end
      default: state_nxt = sdfx_pkg::ST_IDLE;
    endcase
  end

  // outputs: memory access, divider start, result registers
  always_comb begin
    mem_we             = 1'b0;
    mem_waddr          = {bank_r, cell_r};
    mem_wdata          = '0;
    mem_raddr          = {bank_r, cell_r};
    div_start          = 1'b0;
    out_strobe_nxt     = 1'b0;
    out_read_value_nxt = '0;
    out_read_valid_nxt = 1'b0;
    out_status_nxt     = 1'b0;
    unique case (state_r)
      sdfx_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      sdfx_pkg::ST_IDLE: begin
        mem_raddr = {bank_r, in_cell};
        if (start) begin
          if (in_command == sdfx_pkg::CMD_LOAD && in_inside) begin
            mem_we    = 1'b1;
            mem_waddr = {bank_r, in_cell};
            mem_wdata = {in_load_valid, in_load_value};
          end
          if (!(in_command == sdfx_pkg::CMD_READ && in_inside) &&
              !(in_command == sdfx_pkg::CMD_RUN &&
                (ext_passes_r != '0 || smooth_passes_r != '0))) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = (in_command == sdfx_pkg::CMD_LOAD ||
                              in_command == sdfx_pkg::CMD_READ) && !in_inside;
          end
        end
      end
      sdfx_pkg::ST_READ: begin
        out_strobe_nxt     = 1'b1;
        out_read_value_nxt = mem_rdata_r[DW-1:0];
        out_read_valid_nxt = mem_rdata_r[DW];
      end
      sdfx_pkg::ST_GATHER: begin
        mem_raddr = {bank_r, nb_addr};
      end
      sdfx_pkg::ST_DECIDE: begin
        div_start = need_div;
      end
      sdfx_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank_r, cell_r};
        mem_wdata = {res_vld_r, res_val_r};
      end
      sdfx_pkg::ST_PASS_END: begin
        out_strobe_nxt = !more_passes;
      end
      default: ;
    endcase
  end

  assign busy = state_r != sdfx_pkg::ST_IDLE;

  // grid memory, two halves used ping-pong
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sdfx_pkg::ST_CLEAR;
      cell_r       <= '0;
      nb_r         <= '0;
      mode_ext_r   <= 1'b0;
      pass_cnt_r   <= '0;
      bank_r       <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      rd_pend_r    <= state_r == sdfx_pkg::ST_GATHER;
      if (state_r == sdfx_pkg::ST_GATHER) begin
        nb_r <= nb_r + 3'd1;
      end else begin
        nb_r <= '0;
      end
      if (state_r == sdfx_pkg::ST_CLEAR || state_r == sdfx_pkg::ST_WRITE) begin
        cell_r <= cell_r + CW'(1);
      end
      if (accept && in_command == sdfx_pkg::CMD_RUN) begin
        cell_r <= '0;
        if (ext_passes_r != '0) begin
          mode_ext_r <= 1'b1;
          pass_cnt_r <= ext_passes_r;
        end else begin
          mode_ext_r <= 1'b0;
          pass_cnt_r <= smooth_passes_r;
        end
      end
      if (state_r == sdfx_pkg::ST_PASS_END) begin
        bank_r <= ~bank_r;
        if (pass_cnt_r > PASSW'(1)) begin
          pass_cnt_r <= pass_cnt_r - PASSW'(1);
        end else if (mode_ext_r && smooth_passes_r != '0) begin
          mode_ext_r <= 1'b0;
          pass_cnt_r <= smooth_passes_r;
        end
      end
    end
  end

  // per-cell datapath
  always_ff @(posedge clk) begin
    rd_k_r   <= nb_r;
    rd_use_r <= nb_use;
    if (state_r == sdfx_pkg::ST_GATHER && nb_r == 3'd0) begin
      sum_r <= '0;
      n_r   <= '0;
    end else if (rd_pend_r) begin
      if (rd_k_r == 3'd0) begin
        own_val_r <= mem_rdata_r[DW-1:0];
        own_vld_r <= mem_rdata_r[DW];
      end else if (rd_use_r && (!mode_ext_r || mem_rdata_r[DW])) begin
        sum_r <= sum_r + {{(DIVW-DW){mem_rdata_r[DW-1]}}, mem_rdata_r[DW-1:0]};
        n_r   <= n_r + NW'(1);
      end
    end
    if (state_r == sdfx_pkg::ST_DECIDE) begin
      res_val_r <= own_val_r;
      res_vld_r <= own_vld_r;
    end else if (state_r == sdfx_pkg::ST_DIVIDE && div_stat.done) begin
      if (mode_ext_r) begin
        res_val_r <= avg;
        res_vld_r <= 1'b1;
      end else begin
        res_val_r <= (avg < $signed(own_val_r)) ? avg : own_val_r;
        res_vld_r <= own_vld_r;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    out_read_value_r <= out_read_value_nxt;
    out_read_valid_r <= out_read_valid_nxt;
    out_status_r     <= out_status_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_read_value = out_read_value_r;
  assign out_read_valid = out_read_valid_r;
  assign out_status     = out_status_r;

  `include "sdf_extrapolate_smooth_grid_defines.svh"

  `SDFX_ASSERT_SAME(a_status_zero_data, out_strobe_r && out_status_r, out_read_value_r == '0 && !out_read_valid_r, "flagged result carries data")
  `SDFX_ASSERT_NEXT(a_load_one_cycle, accept && in_command == sdfx_pkg::CMD_LOAD, out_strobe_r, "load result missing")
  `SDFX_ASSERT_NEXT(a_pass_flips_bank, state_r == sdfx_pkg::ST_PASS_END, bank_r != $past(bank_r), "pass end kept bank")
  `SDFX_ASSERT_SAME(a_div_only_in_divide, state_r != sdfx_pkg::ST_DIVIDE && state_r != sdfx_pkg::ST_DECIDE, !div_stat.busy, "divider running outside divide")

endmodule

@@ rtl/sdfx_div.sv @@
`include "sdf_extrapolate_smooth_grid_defines.svh"

module sdfx_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sdfx_pkg::DIVW-1:0]    dividend,
  input  logic [sdfx_pkg::NW-1:0]      divisor,
  output sdfx_pkg::div_stat_t          stat,
  output logic [sdfx_pkg::DIVW-1:0]    quotient
);

  localparam int DIVW = sdfx_pkg::DIVW;
  localparam int NW = sdfx_pkg::NW;
  localparam int CNTW = $clog2(DIVW);

  logic              run_r;
  logic              done_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DIVW-1:0]   q_r;
  logic [NW-1:0]     rem_r;
  logic [NW:0]       rem_sh;
  logic [NW:0]       rem_sub;
  logic              fits;
  logic              last;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_r, q_r[DIVW-1]};
    fits    = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
    last    = cnt_r == CNTW'(DIVW-1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && last;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && last) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      q_r   <= {q_r[DIVW-2:0], fits};
      rem_r <= fits ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
      cnt_r <= cnt_r + CNTW'(1);
    end
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

  `SDFX_ASSERT_NEXT(a_div_done_ends_run, run_r && last && !start, !run_r && done_r, "divider overran")
  `SDFX_ASSERT_SAME(a_div_done_not_busy, done_r && !start, !run_r, "divider done while running")
  `SDFX_ASSERT_NEXT(a_div_start_runs, start, run_r, "divider failed to start")

endmodule
